### rtl/kdc_pkg.sv
package kdc_pkg;

  localparam int unsigned STAMP_W = 8;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned ITEM_W  = 46;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic [7:0]         byte_in;
    logic [POS_W-1:0]   byte_position;
    logic [7:0]         add_length;
    logic [STAMP_W-1:0] stamp;
    logic               press_flag;
    logic [7:0]         key_number;
    logic [7:0]         profile_number;
  } item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_VICTIM,
    S_WIPE,
    S_MATCH,
    S_READ,
    S_SEND
  } state_e;

endpackage

### rtl/keyed_data_cache_oldest_replace.sv
// Fully associative cache of ENTRIES keyed entries of ENTRY_BYTES data bytes each, driven one
// word at a time. An add word at a nonzero position is written in its accept cycle, so the
// block is ready again in the next cycle. The word at position 0 of an add with a valid length
// scans the stamps with one comparator, one entry a cycle, stopping early when an empty entry
// turns up, then wipes the victim row of the byte memory one byte a cycle, the first byte
// written on the way. A search compares one key a cycle and then sends each data byte
// through the single registered read port of the byte memory, each byte read in S_READ
// before it is shown in S_SEND; a miss sends one word. After reset the byte memory is zeroed
// in a clearing pass during which no word is accepted.
module keyed_data_cache_oldest_replace #(
  parameter int unsigned ENTRIES     = 4,
  parameter int unsigned ENTRY_BYTES = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // profile_number, key_number, press_flag, stamp, add_length, byte_position, byte_in
  input  logic [kdc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // mode
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit, byte_out, out_position
  output logic [kdc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int unsigned TOTAL = ENTRIES * ENTRY_BYTES;
  localparam int unsigned RW    = $clog2(ENTRIES);
  localparam int unsigned BW    = $clog2(ENTRY_BYTES);
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ENTRIES - 1);
  localparam logic [BW-1:0] LAST_BYTE = BW'(ENTRY_BYTES - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(ENTRY_BYTES);
  localparam logic [8:0]    EB_LIMIT  = 9'(ENTRY_BYTES);

  function automatic logic [AW-1:0] slot_addr(logic [RW-1:0] row, logic [BW-1:0] b);
    slot_addr = AW'(row) * ROW_STEP + AW'(b);
  endfunction

  kdc_pkg::state_e state_q, state_d;
  logic [RW-1:0] idx_q, idx_d;
  logic [RW-1:0] pick_q, pick_d;
  logic [RW-1:0] victim_q, victim_d;
  logic [RW-1:0] row_q, row_d;
  logic [kdc_pkg::STAMP_W-1:0] lowest_q, lowest_d;
  logic [BW-1:0] b_q, b_d;
  logic [AW-1:0] clr_q, clr_d;
  logic found_q, found_d;
  logic add_open_q, add_open_d;
  kdc_pkg::item_t item_q;

  logic [7:0]                  prof_q  [ENTRIES];
  logic [7:0]                  key_q   [ENTRIES];
  logic                        press_q [ENTRIES];
  logic [kdc_pkg::STAMP_W-1:0] stamp_q [ENTRIES];

  logic [7:0] mem [TOTAL];
  logic [7:0] rdata_q;

  kdc_pkg::item_t in_item;
  logic accept;
  logic len_ok;
  logic cont_write;
  logic stamp_zero;
  logic stamp_le;
  logic key_hit;
  logic [RW-1:0] chosen;
  logic tag_we;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  assign in_item = kdc_pkg::item_t'(s_axis_tdata[kdc_pkg::ITEM_W-1:0]);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign len_ok  = (in_item.add_length != 8'd0) && ({1'b0, in_item.add_length} < EB_LIMIT);
  assign cont_write = add_open_q && len_ok &&
                      (in_item.byte_position != '0) &&
                      ({3'b000, in_item.byte_position} < in_item.add_length) &&
                      (9'(in_item.byte_position) < EB_LIMIT);

  assign stamp_zero = (stamp_q[idx_q] == '0);
  assign stamp_le   = (stamp_q[idx_q] <= lowest_q);
  assign chosen     = (stamp_zero || stamp_le) ? idx_q : pick_q;
  assign key_hit    = (prof_q[idx_q] == item_q.profile_number) &&
                      (key_q[idx_q] == item_q.key_number) &&
                      (press_q[idx_q] == item_q.press_flag);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pick_d     = pick_q;
    victim_d   = victim_q;
    row_d      = row_q;
    lowest_d   = lowest_q;
    b_d        = b_q;
    clr_d      = clr_q;
    found_d    = found_q;
    add_open_d = add_open_q;
    case (state_q)
      kdc_pkg::S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = kdc_pkg::S_IDLE;
        end
      end
      kdc_pkg::S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == kdc_pkg::MODE_SEARCH) begin
            idx_d   = '0;
            state_d = kdc_pkg::S_MATCH;
          end else if (in_item.byte_position == '0) begin
            if (len_ok) begin
              idx_d    = '0;
              pick_d   = '0;
              lowest_d = '1;
              state_d  = kdc_pkg::S_VICTIM;
            end else begin
              add_open_d = 1'b0;
            end
          end
        end
      end
      kdc_pkg::S_VICTIM: begin
        if (stamp_zero || idx_q == LAST_ROW) begin
          victim_d = chosen;
          b_d      = '0;
          state_d  = kdc_pkg::S_WIPE;
        end else begin
          if (stamp_le) begin
            lowest_d = stamp_q[idx_q];
            pick_d   = idx_q;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      kdc_pkg::S_WIPE: begin
        b_d = b_q + 1'b1;
        if (b_q == LAST_BYTE) begin
          add_open_d = 1'b1;
          state_d    = kdc_pkg::S_IDLE;
        end
      end
      kdc_pkg::S_MATCH: begin
        if (key_hit) begin
          found_d = 1'b1;
          row_d   = idx_q;
          b_d     = '0;
          state_d = kdc_pkg::S_READ;
        end else if (idx_q == LAST_ROW) begin
          found_d = 1'b0;
          state_d = kdc_pkg::S_SEND;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      kdc_pkg::S_READ: begin
        state_d = kdc_pkg::S_SEND;
      end
      kdc_pkg::S_SEND: begin
        if (m_axis_tready) begin
          if (found_q && b_q != LAST_BYTE) begin
            b_d     = b_q + 1'b1;
            state_d = kdc_pkg::S_READ;
          end else begin
            state_d = kdc_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = kdc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == kdc_pkg::S_IDLE);
    m_axis_tvalid = (state_q == kdc_pkg::S_SEND);
    m_axis_tdata  = '0;
    m_axis_tlast  = 1'b1;
    if (found_q) begin
      m_axis_tdata = {2'b00, kdc_pkg::POS_W'(b_q), rdata_q, 1'b1};
      m_axis_tlast = (b_q == LAST_BYTE);
    end
    tag_we    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = slot_addr(victim_q, b_q);
    mem_wdata = '0;
    mem_raddr = slot_addr(row_q, b_q);
    case (state_q)
      kdc_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      kdc_pkg::S_IDLE: begin
        if (accept && s_axis_tuser == kdc_pkg::MODE_ADD && cont_write) begin
          mem_we    = 1'b1;
          mem_waddr = slot_addr(victim_q, BW'(in_item.byte_position));
          mem_wdata = in_item.byte_in;
        end
      end
      kdc_pkg::S_VICTIM: begin
        tag_we = stamp_zero || (idx_q == LAST_ROW);
      end
      kdc_pkg::S_WIPE: begin
        mem_we    = 1'b1;
        mem_wdata = (b_q == '0) ? item_q.byte_in : 8'd0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kdc_pkg::S_CLEAR;
      idx_q      <= '0;
      pick_q     <= '0;
      victim_q   <= '0;
      row_q      <= '0;
      lowest_q   <= '1;
      b_q        <= '0;
      clr_q      <= '0;
      found_q    <= 1'b0;
      add_open_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      pick_q     <= pick_d;
      victim_q   <= victim_d;
      row_q      <= row_d;
      lowest_q   <= lowest_d;
      b_q        <= b_d;
      clr_q      <= clr_d;
      found_q    <= found_d;
      add_open_q <= add_open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        prof_q[i]  <= '0;
        key_q[i]   <= '0;
        press_q[i] <= 1'b0;
        stamp_q[i] <= '0;
      end
    end else if (tag_we) begin
      prof_q[chosen]  <= item_q.profile_number;
      key_q[chosen]   <= item_q.key_number;
      press_q[chosen] <= item_q.press_flag;
      stamp_q[chosen] <= item_q.stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_miss_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tlast)
    else $error("A miss word must close the search.");

  a_search_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == kdc_pkg::MODE_SEARCH) |=> !s_axis_tready)
    else $error("A search must hold off the input side.");

  a_read_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !m_axis_tvalid)
    else $error("Each data word needs a read cycle before it is shown.");

  a_open_after_wipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(add_open_q) |-> ($past(state_q) == kdc_pkg::S_WIPE))
    else $error("An add may only open once its row is wiped.");

  a_no_output_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kdc_pkg::S_CLEAR) |-> (!m_axis_tvalid && !s_axis_tready))
    else $error("Both sides must stay quiet during the clearing pass.");
`endif

endmodule

### sim/tb.sv
module tb;

  localparam int unsigned ROWS      = 4;
  localparam int unsigned ROW_BYTES = 32;
  localparam int unsigned WORDS     = 470;

  typedef struct packed {
    logic           mode;
    kdc_pkg::item_t item;
  } word_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] data;
    logic [4:0] pos;
    logic       last;
  } reply_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [kdc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [kdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;

  word_t  pending_words[$];
  reply_t search_bytes_q[$];
  int     fail_count = 0;
  int     words_sent = 0;

  logic [7:0] row_profile[ROWS];
  logic [7:0] row_key[ROWS];
  logic       row_press[ROWS];
  logic [7:0] row_stamp[ROWS];
  logic [7:0] row_data[ROWS][ROW_BYTES];
  int         fill_row;
  logic       fill_open;

  keyed_data_cache_oldest_replace #(
    .ENTRIES    (ROWS),
    .ENTRY_BYTES(ROW_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int oldest_row();
    int i;
    int low;
    int pick;
    low = 256;
    pick = 0;
    for (i = 0; i < ROWS; i++) begin
      if (row_stamp[i] == 8'd0) return i;
      if (row_stamp[i] <= low) begin
        low = row_stamp[i];
        pick = i;
      end
    end
    return pick;
  endfunction

  // Applies one accepted word to the shadow cache and queues the bytes a search returns.
  task automatic apply_to_cache(input logic mode, input kdc_pkg::item_t w);
    logic   len_ok;
    int     i;
    int     b;
    int     found;
    reply_t r;
    len_ok = (w.add_length != 8'd0) && (w.add_length < ROW_BYTES);
    if (mode == kdc_pkg::MODE_ADD) begin
      if (w.byte_position == '0) begin
        if (!len_ok) begin
          fill_open = 1'b0;
          return;
        end
        fill_row = oldest_row();
        row_profile[fill_row] = w.profile_number;
        row_key[fill_row] = w.key_number;
        row_press[fill_row] = w.press_flag;
        row_stamp[fill_row] = w.stamp;
        for (b = 0; b < ROW_BYTES; b++) row_data[fill_row][b] = 8'd0;
        fill_open = 1'b1;
      end
      if (fill_open && len_ok && (w.byte_position < w.add_length)) begin
        row_data[fill_row][w.byte_position] = w.byte_in;
      end
    end else begin
      found = -1;
      for (i = ROWS - 1; i >= 0; i--) begin
        if (row_profile[i] == w.profile_number && row_key[i] == w.key_number &&
            row_press[i] == w.press_flag) begin
          found = i;
        end
      end
      if (found < 0) begin
        r = '{hit: 1'b0, data: 8'd0, pos: 5'd0, last: 1'b1};
        search_bytes_q.push_back(r);
      end else begin
        for (b = 0; b < ROW_BYTES; b++) begin
          r.hit = 1'b1;
          r.data = row_data[found][b];
          r.pos = b[4:0];
          r.last = (b == ROW_BYTES - 1);
          search_bytes_q.push_back(r);
        end
      end
    end
  endtask

  function automatic kdc_pkg::item_t any_item();
    kdc_pkg::item_t it;
    it = kdc_pkg::item_t'(kdc_pkg::ITEM_W'({$urandom, $urandom}));
    return it;
  endfunction

  task automatic push_word(input logic mode, input logic [7:0] prof, input logic [7:0] key,
                           input logic press, input logic [7:0] stamp, input logic [7:0] len,
                           input logic [4:0] pos, input logic [7:0] data);
    word_t w;
    w.mode = mode;
    w.item.profile_number = prof;
    w.item.key_number = key;
    w.item.press_flag = press;
    w.item.stamp = stamp;
    w.item.add_length = len;
    w.item.byte_position = pos;
    w.item.byte_in = data;
    pending_words.push_back(w);
  endtask

  task automatic push_item(input logic mode, input kdc_pkg::item_t it);
    word_t w;
    w.mode = mode;
    w.item = it;
    pending_words.push_back(w);
  endtask

  // Sender: a new word is offered once the current one has been taken.
  kdc_pkg::item_t taken_item;
  word_t          next_word;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken_item = kdc_pkg::item_t'(s_axis_tdata[kdc_pkg::ITEM_W-1:0]);
        apply_to_cache(s_axis_tuser, taken_item);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 &&
            ((words_sent >= 150 && words_sent < 230) || $urandom_range(0, 99) >= 33)) begin
          next_word = pending_words.pop_front();
          words_sent <= words_sent + 1;
          s_axis_tdata <= {{(kdc_pkg::IN_TDATA_W - kdc_pkg::ITEM_W){1'b0}}, next_word.item};
          s_axis_tuser <= next_word.mode;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off once output is waiting, and a calm stretch.
  int   rx_cycles = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && rx_cycles >= 1500 && m_axis_tvalid) begin
        hold_left <= 400;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else if (rx_cycles >= 4000 && rx_cycles < 6000) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 33);
      end
    end
  end

  reply_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (search_bytes_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual tdata %h tlast %b", $time,
                 m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = search_bytes_q.pop_front();
        if (m_axis_tdata[0] !== want.hit) begin
          $display("%0t: hit mismatch, expected %h, actual %h", $time, want.hit,
                   m_axis_tdata[0]);
          fail_count++;
        end
        if (m_axis_tdata[8:1] !== want.data) begin
          $display("%0t: byte_out mismatch, expected %h, actual %h", $time, want.data,
                   m_axis_tdata[8:1]);
          fail_count++;
        end
        if (m_axis_tdata[13:9] !== want.pos) begin
          $display("%0t: out_position mismatch, expected %h, actual %h", $time, want.pos,
                   m_axis_tdata[13:9]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last_byte mismatch, expected %h, actual %h", $time, want.last,
                   m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  logic [16:0]    key_pool[6];
  kdc_pkg::item_t it;
  int             sel;
  int             len;
  int             k;
  int             p;
  int             i;

  initial begin
    for (i = 0; i < ROWS; i++) begin
      row_profile[i] = 8'd0;
      row_key[i] = 8'd0;
      row_press[i] = 1'b0;
      row_stamp[i] = 8'd0;
      for (p = 0; p < ROW_BYTES; p++) row_data[i][p] = 8'd0;
    end
    fill_row = 0;
    fill_open = 1'b0;

    // Key zero hits a cleared entry; the same key with press set misses.
    push_word(kdc_pkg::MODE_SEARCH, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 5'd0, 8'h00);
    push_word(kdc_pkg::MODE_SEARCH, 8'h00, 8'h00, 1'b1, 8'hFF, 8'hFF, 5'd31, 8'hFF);
    // Starts with three bad lengths, then a continuation with no add open.
    push_word(kdc_pkg::MODE_ADD, 8'h12, 8'h34, 1'b1, 8'h09, 8'd0, 5'd0, 8'h5A);
    push_word(kdc_pkg::MODE_ADD, 8'h12, 8'h34, 1'b1, 8'h09, 8'd32, 5'd0, 8'h5A);
    push_word(kdc_pkg::MODE_ADD, 8'h12, 8'h34, 1'b1, 8'h09, 8'd255, 5'd0, 8'h5A);
    push_word(kdc_pkg::MODE_ADD, 8'h12, 8'h34, 1'b1, 8'h09, 8'd10, 5'd5, 8'h5A);
    // Short add with extreme fields, then bytes within and beyond its length.
    push_word(kdc_pkg::MODE_ADD, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'd3, 5'd0, 8'hFF);
    push_word(kdc_pkg::MODE_ADD, 8'h00, 8'h00, 1'b0, 8'h00, 8'd3, 5'd1, 8'h00);
    push_word(kdc_pkg::MODE_ADD, 8'h77, 8'h66, 1'b0, 8'h55, 8'd3, 5'd2, 8'hA5);
    push_word(kdc_pkg::MODE_ADD, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'd3, 5'd3, 8'h77);
    push_word(kdc_pkg::MODE_ADD, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'd3, 5'd31, 8'h88);
    // Longest add, searched while still open.
    push_word(kdc_pkg::MODE_ADD, 8'h01, 8'h02, 1'b0, 8'h01, 8'd31, 5'd0, 8'h11);
    push_word(kdc_pkg::MODE_ADD, 8'hEE, 8'hDD, 1'b1, 8'hCC, 8'd31, 5'd1, 8'h22);
    push_word(kdc_pkg::MODE_SEARCH, 8'h01, 8'h02, 1'b0, 8'h00, 8'h00, 5'd0, 8'h00);
    push_word(kdc_pkg::MODE_ADD, 8'h01, 8'h02, 1'b0, 8'h01, 8'd31, 5'd30, 8'hEE);
    push_word(kdc_pkg::MODE_SEARCH, 8'h01, 8'h02, 1'b0, 8'h00, 8'h00, 5'd0, 8'h00);
    // Equal stamps: the oldest tie is broken toward the higher entry.
    push_word(kdc_pkg::MODE_ADD, 8'hAA, 8'h55, 1'b0, 8'h05, 8'd1, 5'd0, 8'h3C);
    push_word(kdc_pkg::MODE_ADD, 8'h55, 8'hAA, 1'b1, 8'h05, 8'd1, 5'd0, 8'hC3);
    push_word(kdc_pkg::MODE_ADD, 8'h10, 8'h20, 1'b1, 8'h07, 8'd2, 5'd0, 8'h01);
    push_word(kdc_pkg::MODE_ADD, 8'h30, 8'h40, 1'b0, 8'h09, 8'd1, 5'd0, 8'h02);
    push_word(kdc_pkg::MODE_SEARCH, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00, 5'd0, 8'h00);
    push_word(kdc_pkg::MODE_SEARCH, 8'h55, 8'hAA, 1'b1, 8'h00, 8'h00, 5'd0, 8'h00);
    push_word(kdc_pkg::MODE_SEARCH, 8'hAA, 8'h55, 1'b0, 8'h00, 8'h00, 5'd0, 8'h00);
    push_word(kdc_pkg::MODE_SEARCH, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 5'd0, 8'h00);

    for (k = 0; k < 6; k++) key_pool[k] = 17'($urandom);
    while (pending_words.size() < WORDS) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        len = ($urandom_range(0, 5) == 0) ? 31 : $urandom_range(1, 8);
        k = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) key_pool[k] = 17'($urandom);
        it = any_item();
        {it.press_flag, it.key_number, it.profile_number} = key_pool[k];
        if ($urandom_range(0, 6) == 0) it.stamp = 8'd0;
        it.add_length = 8'(len);
        it.byte_position = 5'd0;
        push_item(kdc_pkg::MODE_ADD, it);
        for (p = 1; p < len; p++) begin
          if ($urandom_range(0, 19) == 0) break;
          it = any_item();
          it.add_length = 8'(len);
          it.byte_position = 5'(p);
          push_item(kdc_pkg::MODE_ADD, it);
          if ($urandom_range(0, 24) == 0) begin
            it = any_item();
            {it.press_flag, it.key_number, it.profile_number} = key_pool[k];
            push_item(kdc_pkg::MODE_SEARCH, it);
          end
        end
        if ($urandom_range(0, 4) == 0) begin
          it = any_item();
          it.add_length = 8'(len);
          it.byte_position = 5'($urandom_range(len, 31));
          push_item(kdc_pkg::MODE_ADD, it);
        end
      end else if (sel < 85) begin
        it = any_item();
        k = $urandom_range(0, 9);
        if (k < 7) begin
          {it.press_flag, it.key_number, it.profile_number} = key_pool[$urandom_range(0, 5)];
        end else if (k == 7) begin
          {it.press_flag, it.key_number, it.profile_number} = '0;
        end
        push_item(kdc_pkg::MODE_SEARCH, it);
      end else begin
        it = any_item();
        if ($urandom_range(0, 1) == 0) begin
          it.byte_position = 5'd0;
          it.add_length = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(32, 255));
          push_item(kdc_pkg::MODE_ADD, it);
        end else begin
          push_item(1'($urandom_range(0, 1)), it);
        end
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || s_axis_tvalid || search_bytes_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (200) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
